@@ rtl/core/fde_pkg.sv @@
// Shared types, constants and helper functions for the framebuffer draw engine.
// Used by every module under rtl/core except the generic RAM.
package fde_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);

  localparam int DIM_W      = 9;
  localparam int COORD_W    = 11;
  localparam int PCOORD_W   = 12;
  localparam int SIZE_W     = 10;
  localparam int COLOR_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 30;
  localparam int SIDE_W     = 11;
  localparam int NUM_W      = SIDE_W + FRAC_W + 1;
  localparam int QUO_W      = FRAC_W + 2;
  localparam int DCNT_W     = $clog2(NUM_W);

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [COLOR_W-1:0] GRID_COLOR = 32'hff333333;
  localparam int GRID_STEP = 10;

  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_GRID  = 3'd1;
  localparam logic [2:0] ACT_PIXEL = 3'd2;
  localparam logic [2:0] ACT_RECT  = 3'd3;
  localparam logic [2:0] ACT_LINE  = 3'd4;
  localparam logic [2:0] ACT_TRI   = 3'd5;
  localparam logic [2:0] ACT_READ  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    K_NOP, K_CLEAR, K_GRID, K_PIXEL, K_RECT, K_LINE, K_TRI, K_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [COORD_W-1:0]   x0;
    logic signed [COORD_W-1:0]   y0;
    logic signed [COORD_W-1:0]   x1;
    logic signed [COORD_W-1:0]   y1;
    logic signed [COORD_W-1:0]   x2;
    logic signed [COORD_W-1:0]   y2;
    logic [SIZE_W-1:0]           bw;
    logic [SIZE_W-1:0]           bh;
    logic [COLOR_W-1:0]          color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CLEAR, B_GRID, B_PIXEL, B_RECT, B_LSETUP, B_DIV, B_LINE,
    B_READ, B_RWAIT, B_DONE
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned mx);
    if (v == '0) return DIM_W'(1);
    if (32'(v) > mx) return DIM_W'(mx);
    return v;
  endfunction

endpackage

@@ rtl/core/framebuffer_draw_engine.sv @@
// Framebuffer draw engine: 2D drawing commands (clear, grid, pixel, rectangle,
// DDA line, triangle, pixel read) over a frame of 32-bit colors.
//
// Input channel s_axis: one transfer is one command; tuser carries the action.
// Output channel m_axis: exactly one result transfer per command, in order.
// Configuration channel cfg: index 0 sets the screen width, index 1 the height
// (0 acts as 1, values above the maximum are clamped); always ready. Write it
// only while no command is outstanding.
// The back end issues one pixel per cycle into a single-port write path. Clear
// draws width*height pixels, grid one per dot, a rectangle box_width*box_height
// pixels and a line a setup step, an iterative divide (none for a zero-length
// line) and then its longer axis length plus one pixels; a triangle is three
// lines.
// A queue of two commands plus a front register lets new commands be taken
// while the back end draws; when the receiver stalls, the result register
// holds and the back end waits, and the input side fills and then deasserts
// tready. Reset clears all control state and sets the screen to its maximum;
// the frame memory is not cleared and is undefined until drawn.
// Depends on fde_pkg, fde_ram, fde_cmd_fifo, fde_front and fde_back.
module framebuffer_draw_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y, box_width,
  // box_height, paint, zero pad
  input  logic [fde_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_color, inside_res, zero pad
  output logic [fde_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fde_pkg::DIM_W-1:0]       cfg_data
);
  import fde_pkg::*;

  logic [DIM_W-1:0]   width, height;
  logic               push, pop;
  cmd_t               push_cmd, fifo_out;
  fifo_stat_t         fstat;
  logic [COLOR_W-1:0] res_color;
  logic               res_flag;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [COLOR_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= DIM_W'(MAX_WIDTH);
      height <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width  <= clamp_dim(cfg_data, MAX_WIDTH);
        REG_HEIGHT: height <= clamp_dim(cfg_data, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  fde_front u_front (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .push, .push_cmd, .fstat
  );

  fde_cmd_fifo u_fifo (
    .clk, .rst, .push, .din(push_cmd), .pop, .dout(fifo_out), .stat(fstat)
  );

  fde_back u_back (
    .clk, .rst, .cmd(fifo_out), .fstat, .pop, .width, .height,
    .res_vld(m_axis_tvalid), .res_color, .res_flag, .res_ready(m_axis_tready),
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata
  );

  fde_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_frame (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-COLOR_W-1){1'b0}}, res_flag, res_color};

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fstat.full |-> !push) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fstat.empty) else $error("command queue underflow");
  a_color_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !res_flag) |-> (res_color == '0))
    else $error("read color without an on-screen hit");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("result valid after reset");
`endif
endmodule

@@ rtl/core/fde_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Has no dependencies.
module fde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/fde_cmd_fifo.sv @@
// Short command queue between the front end and the drawing back end.
// Depends on fde_pkg.
module fde_cmd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fde_pkg::cmd_t      din,
  input  logic               pop,
  output fde_pkg::cmd_t      dout,
  output fde_pkg::fifo_stat_t stat
);
  import fde_pkg::*;

  cmd_t              slots [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr;
  logic [FPTR_W-1:0] rd_ptr;
  logic [FCNT_W-1:0] count;

  assign dout       = slots[rd_ptr];
  assign stat.full  = (count == FCNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule

@@ rtl/core/fde_front.sv @@
// Front end: takes input transfers, decodes the action into a command kind
// and forwards it to the command queue. Depends on fde_pkg.
module fde_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fde_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [2:0]                    s_axis_tuser,
  output logic                          push,
  output fde_pkg::cmd_t                 push_cmd,
  input  fde_pkg::fifo_stat_t           fstat
);
  import fde_pkg::*;

  logic      held;
  cmd_t      dec;
  cmd_kind_t kind;

  assign push          = held && !fstat.full;
  assign s_axis_tready = !held || push;

  always_comb begin
    dec.x0    = s_axis_tdata[10:0];
    dec.y0    = s_axis_tdata[21:11];
    dec.x1    = s_axis_tdata[32:22];
    dec.y1    = s_axis_tdata[43:33];
    dec.x2    = s_axis_tdata[54:44];
    dec.y2    = s_axis_tdata[65:55];
    dec.bw    = s_axis_tdata[75:66];
    dec.bh    = s_axis_tdata[85:76];
    dec.color = s_axis_tdata[117:86];
    unique case (s_axis_tuser)
      ACT_CLEAR: kind = K_CLEAR;
      ACT_GRID:  kind = K_GRID;
      ACT_PIXEL: kind = K_PIXEL;
      // An empty rectangle draws nothing, so it is dropped to a no-op here.
      ACT_RECT:  kind = (dec.bw == '0 || dec.bh == '0) ? K_NOP : K_RECT;
      ACT_LINE:  kind = K_LINE;
      ACT_TRI:   kind = K_TRI;
      ACT_READ:  kind = K_READ;
      default:   kind = K_NOP;
    endcase
    dec.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      push_cmd <= dec;
    end
  end
endmodule

@@ rtl/core/fde_back.sv @@
// Back end: executes one command at a time, emitting one pixel per cycle into
// a write stage, with an iterative divider for line steps. Depends on fde_pkg.
module fde_back (
  input  logic                        clk,
  input  logic                        rst,
  input  fde_pkg::cmd_t               cmd,
  input  fde_pkg::fifo_stat_t         fstat,
  output logic                        pop,
  input  logic [fde_pkg::DIM_W-1:0]   width,
  input  logic [fde_pkg::DIM_W-1:0]   height,
  output logic                        res_vld,
  output logic [fde_pkg::COLOR_W-1:0] res_color,
  output logic                        res_flag,
  input  logic                        res_ready,
  output logic                        ram_we,
  output logic [fde_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [fde_pkg::COLOR_W-1:0] ram_wdata,
  output logic [fde_pkg::ADDR_W-1:0]  ram_raddr,
  input  logic [fde_pkg::COLOR_W-1:0] ram_rdata
);
  import fde_pkg::*;

  function automatic logic on_scr(input logic signed [PCOORD_W-1:0] x,
                                  input logic signed [PCOORD_W-1:0] y,
                                  input logic [DIM_W-1:0] w,
                                  input logic [DIM_W-1:0] h);
    return !x[PCOORD_W-1] && !y[PCOORD_W-1] &&
           ($unsigned(x) < {{(PCOORD_W-DIM_W){1'b0}}, w}) &&
           ($unsigned(y) < {{(PCOORD_W-DIM_W){1'b0}}, h});
  endfunction

  // Round a Q.16 value to the nearest integer, halves away from zero.
  function automatic logic signed [PCOORD_W-1:0] round_q16(
      input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] r;
    mag = v[ACC_W-1] ? -v : v;
    r   = (mag + ACC_W'(1 << (FRAC_W - 1))) >> FRAC_W;
    return v[ACC_W-1] ? -r[PCOORD_W-1:0] : r[PCOORD_W-1:0];
  endfunction

  back_state_t state, state_next;
  cmd_t        c;
  logic [SIZE_W-1:0] cnt_i, cnt_j;
  logic [1:0]        seg;
  logic [SIDE_W-1:0] side, step;
  logic              neg_x, neg_y;
  logic [NUM_W-1:0]  nx, ny;
  logic [SIDE_W-1:0] rx, ry;
  logic [DCNT_W-1:0] div_cnt;
  logic signed [ACC_W-1:0] cx, cy, ix, iy;
  logic [COLOR_W-1:0] r_color;
  logic               r_flag;

  logic                       pix_vld;
  logic signed [PCOORD_W-1:0] pix_x, pix_y;
  logic [COLOR_W-1:0]         pix_color;

  logic                       gen_vld;
  logic signed [PCOORD_W-1:0] gen_x, gen_y;
  logic [COLOR_W-1:0]         gen_color;

  logic                       last_pix;
  logic                       res_load;

  // Segment endpoints and axis lengths for the current line.
  logic signed [COORD_W-1:0]  sx, sy, ex, ey;
  logic signed [PCOORD_W-1:0] dx, dy;
  logic [SIDE_W-1:0]          ax, ay, side_new;

  // One restoring divider step per lane.
  logic [SIDE_W:0]    shx, shy;
  logic               gex, gey;
  logic [NUM_W-1:0]   nx_new, ny_new;
  logic [SIDE_W-1:0]  rx_new, ry_new;

  logic signed [PCOORD_W-1:0] rd_x, rd_y;
  logic [ADDR_W-1:0]          rd_row, wr_row;

  always_comb begin
    unique case (seg)
      2'd0: begin sx = c.x0; sy = c.y0; ex = c.x1; ey = c.y1; end
      2'd1: begin sx = c.x1; sy = c.y1; ex = c.x2; ey = c.y2; end
      default: begin sx = c.x2; sy = c.y2; ex = c.x0; ey = c.y0; end
    endcase
    dx = {ex[COORD_W-1], ex} - {sx[COORD_W-1], sx};
    dy = {ey[COORD_W-1], ey} - {sy[COORD_W-1], sy};
    ax = dx[PCOORD_W-1] ? SIDE_W'(-dx) : dx[SIDE_W-1:0];
    ay = dy[PCOORD_W-1] ? SIDE_W'(-dy) : dy[SIDE_W-1:0];
    side_new = (ax >= ay) ? ax : ay;

    shx    = {rx, nx[NUM_W-1]};
    shy    = {ry, ny[NUM_W-1]};
    gex    = shx >= {1'b0, side};
    gey    = shy >= {1'b0, side};
    rx_new = gex ? SIDE_W'(shx - {1'b0, side}) : shx[SIDE_W-1:0];
    ry_new = gey ? SIDE_W'(shy - {1'b0, side}) : shy[SIDE_W-1:0];
    nx_new = {nx[NUM_W-2:0], gex};
    ny_new = {ny[NUM_W-2:0], gey};
  end

  // Pixel source and end-of-run detection for the current state.
  always_comb begin
    gen_vld   = 1'b0;
    gen_x     = {2'b00, cnt_i};
    gen_y     = {2'b00, cnt_j};
    gen_color = c.color;
    last_pix  = 1'b0;
    case (state)
      B_CLEAR: begin
        gen_vld  = 1'b1;
        last_pix = (cnt_i == SIZE_W'(width) - 1'b1) &&
                   (cnt_j == SIZE_W'(height) - 1'b1);
      end
      B_GRID: begin
        gen_vld   = 1'b1;
        gen_color = GRID_COLOR;
        last_pix  = (({1'b0, cnt_i} + (SIZE_W+1)'(GRID_STEP)) >= (SIZE_W+1)'(width)) &&
                    (({1'b0, cnt_j} + (SIZE_W+1)'(GRID_STEP)) >= (SIZE_W+1)'(height));
      end
      B_PIXEL: begin
        gen_vld = 1'b1;
        gen_x   = {c.x0[COORD_W-1], c.x0};
        gen_y   = {c.y0[COORD_W-1], c.y0};
      end
      B_RECT: begin
        gen_vld  = 1'b1;
        gen_x    = {c.x0[COORD_W-1], c.x0} + {2'b00, cnt_i};
        gen_y    = {c.y0[COORD_W-1], c.y0} + {2'b00, cnt_j};
        last_pix = (cnt_i == c.bw - 1'b1) && (cnt_j == c.bh - 1'b1);
      end
      B_LINE: begin
        gen_vld  = 1'b1;
        gen_x    = round_q16(cx);
        gen_y    = round_q16(cy);
        last_pix = (step == side);
      end
      default: ;
    endcase
  end

  assign res_load = (state == B_DONE) && (!res_vld || res_ready);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!fstat.empty) begin
          pop = 1'b1;
          unique case (cmd.kind)
            K_CLEAR:       state_next = B_CLEAR;
            K_GRID:        state_next = B_GRID;
            K_PIXEL:       state_next = B_PIXEL;
            K_RECT:        state_next = B_RECT;
            K_LINE, K_TRI: state_next = B_LSETUP;
            K_READ:        state_next = B_READ;
            default:       state_next = B_DONE;
          endcase
        end
      end
      B_CLEAR, B_GRID, B_RECT: if (last_pix) state_next = B_DONE;
      B_PIXEL:  state_next = B_DONE;
      B_LSETUP: state_next = (side_new == '0) ? B_LINE : B_DIV;
      B_DIV:    if (div_cnt == DCNT_W'(NUM_W - 1)) state_next = B_LINE;
      B_LINE: begin
        if (last_pix) begin
          state_next = (c.kind == K_TRI && seg != 2'd2) ? B_LSETUP : B_DONE;
        end
      end
      B_READ:   if (!pix_vld) state_next = B_RWAIT;
      B_RWAIT:  state_next = B_DONE;
      B_DONE:   if (res_load) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      pix_vld <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      state   <= state_next;
      pix_vld <= gen_vld;
      if (res_load)       res_vld <= 1'b1;
      else if (res_ready) res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pix_x     <= gen_x;
    pix_y     <= gen_y;
    pix_color <= gen_color;
    if (res_load) begin
      res_color <= r_color;
      res_flag  <= r_flag;
    end
    case (state)
      B_IDLE: begin
        c       <= cmd;
        cnt_i   <= '0;
        cnt_j   <= '0;
        seg     <= '0;
        r_color <= '0;
        r_flag  <= 1'b0;
      end
      B_CLEAR: begin
        if (cnt_i == SIZE_W'(width) - 1'b1) begin
          cnt_i <= '0;
          cnt_j <= cnt_j + 1'b1;
        end else begin
          cnt_i <= cnt_i + 1'b1;
        end
      end
      B_GRID: begin
        if (({1'b0, cnt_i} + (SIZE_W+1)'(GRID_STEP)) >= (SIZE_W+1)'(width)) begin
          cnt_i <= '0;
          cnt_j <= cnt_j + SIZE_W'(GRID_STEP);
        end else begin
          cnt_i <= cnt_i + SIZE_W'(GRID_STEP);
        end
      end
      B_PIXEL: r_flag <= on_scr(gen_x, gen_y, width, height);
      B_RECT: begin
        if (cnt_j == c.bh - 1'b1) begin
          cnt_j <= '0;
          cnt_i <= cnt_i + 1'b1;
        end else begin
          cnt_j <= cnt_j + 1'b1;
        end
      end
      B_LSETUP: begin
        side    <= side_new;
        neg_x   <= dx[PCOORD_W-1];
        neg_y   <= dy[PCOORD_W-1];
        nx      <= NUM_W'({ax, {FRAC_W{1'b0}}}) + NUM_W'(side_new >> 1);
        ny      <= NUM_W'({ay, {FRAC_W{1'b0}}}) + NUM_W'(side_new >> 1);
        rx      <= '0;
        ry      <= '0;
        div_cnt <= '0;
        step    <= '0;
        ix      <= '0;
        iy      <= '0;
        cx      <= {{(ACC_W-FRAC_W-COORD_W){sx[COORD_W-1]}}, sx, {FRAC_W{1'b0}}};
        cy      <= {{(ACC_W-FRAC_W-COORD_W){sy[COORD_W-1]}}, sy, {FRAC_W{1'b0}}};
      end
      B_DIV: begin
        nx      <= nx_new;
        ny      <= ny_new;
        rx      <= rx_new;
        ry      <= ry_new;
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == DCNT_W'(NUM_W - 1)) begin
          ix <= neg_x ? -ACC_W'(nx_new[QUO_W-1:0]) : ACC_W'(nx_new[QUO_W-1:0]);
          iy <= neg_y ? -ACC_W'(ny_new[QUO_W-1:0]) : ACC_W'(ny_new[QUO_W-1:0]);
        end
      end
      B_LINE: begin
        cx   <= cx + ix;
        cy   <= cy + iy;
        step <= step + 1'b1;
        if (last_pix) seg <= seg + 1'b1;
      end
      B_RWAIT: begin
        if (on_scr(rd_x, rd_y, width, height)) begin
          r_color <= ram_rdata;
          r_flag  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Write stage: clip, then address = y * stride + x.
  assign rd_x      = {c.x0[COORD_W-1], c.x0};
  assign rd_y      = {c.y0[COORD_W-1], c.y0};
  assign wr_row    = ADDR_W'(pix_y[Y_W-1:0]) * ADDR_W'(width);
  assign rd_row    = ADDR_W'(rd_y[Y_W-1:0]) * ADDR_W'(width);
  assign ram_we    = pix_vld && on_scr(pix_x, pix_y, width, height);
  assign ram_waddr = wr_row + ADDR_W'(pix_x[X_W-1:0]);
  assign ram_wdata = pix_color;
  assign ram_raddr = rd_row + ADDR_W'(rd_x[X_W-1:0]);
endmodule

@@ sim/framebuffer_draw_engine_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the framebuffer draw engine.
// It drives command and register transfers and checks every result against a predictor
// that keeps its own copy of the frame. Depends on fde_pkg and the engine RTL.
module framebuffer_draw_engine_tb;
  import fde_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  // Action code with no drawing behind it, and register indexes past the list.
  localparam logic [2:0]           ACT_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 2'd3;

  typedef struct {
    logic [2:0]                 act;
    logic signed [COORD_W-1:0]  x0, y0, x1, y1, x2, y2;
    logic [SIZE_W-1:0]          bw, bh;
    logic [COLOR_W-1:0]         paint;
  } draw_cmd_t;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic               hit;
  } draw_result_t;

  class frame_scoreboard;
    logic [COLOR_W-1:0] frame_mem [DEPTH];
    int                 scr_w = MAX_WIDTH;
    int                 scr_h = MAX_HEIGHT;
    draw_result_t       pending [$];
    int                 errors = 0;

    task report(string what, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    function int clamp_size(logic [DIM_W-1:0] v, int mx);
      if (v == 0) return 1;
      if (int'(v) > mx) return mx;
      return int'(v);
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
      if (idx == REG_WIDTH) scr_w = clamp_size(v, MAX_WIDTH);
      else if (idx == REG_HEIGHT) scr_h = clamp_size(v, MAX_HEIGHT);
    endfunction

    function bit on_screen(int x, int y);
      return x >= 0 && y >= 0 && x < scr_w && y < scr_h;
    endfunction

    function bit plot(int x, int y, logic [COLOR_W-1:0] c);
      if (!on_screen(x, y)) return 0;
      frame_mem[y * scr_w + x] = c;
      return 1;
    endfunction

    function int round_fix(longint v);
      if (v >= 0) return int'((v + 32768) / 65536);
      return -int'(((-v) + 32768) / 65536);
    endfunction

    function longint step_fix(int d, int side);
      longint mag, q;
      mag = longint'(d < 0 ? -d : d) * 65536;
      q = (mag + side / 2) / side;
      return d < 0 ? -q : q;
    endfunction

    function void trace_segment(int xa, int ya, int xb, int yb, logic [COLOR_W-1:0] c);
      int     dx, dy, ax, ay, side;
      longint cx, cy, ix, iy;
      bit     dummy;
      dx = xb - xa; dy = yb - ya;
      ax = dx < 0 ? -dx : dx; ay = dy < 0 ? -dy : dy;
      side = ax >= ay ? ax : ay;
      cx = longint'(xa) * 65536; cy = longint'(ya) * 65536;
      ix = 0; iy = 0;
      if (side > 0) begin
        ix = step_fix(dx, side);
        iy = step_fix(dy, side);
      end
      for (int i = 0; i <= side; i++) begin
        dummy = plot(round_fix(cx), round_fix(cy), c);
        cx += ix;
        cy += iy;
      end
    endfunction

    function void note(draw_cmd_t c);
      draw_result_t r;
      int x0, y0, x1, y1, x2, y2;
      bit dummy;
      x0 = c.x0; y0 = c.y0; x1 = c.x1; y1 = c.y1; x2 = c.x2; y2 = c.y2;
      r.color = '0;
      r.hit = 1'b0;
      case (c.act)
        ACT_CLEAR:
          for (int y = 0; y < scr_h; y++)
            for (int x = 0; x < scr_w; x++) frame_mem[y * scr_w + x] = c.paint;
        ACT_GRID:
          for (int y = 0; y < scr_h; y += GRID_STEP)
            for (int x = 0; x < scr_w; x += GRID_STEP) frame_mem[y * scr_w + x] = GRID_COLOR;
        ACT_PIXEL: r.hit = plot(x0, y0, c.paint);
        ACT_RECT:
          for (int i = 0; i < int'(c.bw); i++)
            for (int j = 0; j < int'(c.bh); j++) dummy = plot(x0 + i, y0 + j, c.paint);
        ACT_LINE: trace_segment(x0, y0, x1, y1, c.paint);
        ACT_TRI: begin
          trace_segment(x0, y0, x1, y1, c.paint);
          trace_segment(x1, y1, x2, y2, c.paint);
          trace_segment(x2, y2, x0, y0, c.paint);
        end
        ACT_READ:
          if (on_screen(x0, y0)) begin
            r.hit = 1'b1;
            r.color = frame_mem[y0 * scr_w + x0];
          end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task check(logic [COLOR_W-1:0] color, logic hit);
      draw_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", color, 0);
        return;
      end
      want = pending.pop_front();
      if (color !== want.color) report("read_color", color, want.color);
      if (hit !== want.hit) report("inside_res", hit, want.hit);
    endtask
  endclass

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   s_axis_tvalid = 0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [2:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid = 0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]       cfg_data = '0;

  frame_scoreboard board = new();
  int  cycles = 0;
  bit  no_gaps = 0;

  framebuffer_draw_engine dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[framebuffer_draw_engine] ERROR");
      $finish;
    end
  end

  function int pick_gap();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  // Receiver: random stalls, one check per result transfer.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check(m_axis_tdata[31:0], m_axis_tdata[32]);
    end
  end

  task send_cmd(draw_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.act;
    s_axis_tdata  <= {2'b00, c.paint, c.bh, c.bw, c.y2, c.x2, c.y1, c.x1, c.y0, c.x0};
    do @(posedge clk); while (!s_axis_tready);
    board.note(c);
  endtask

  // Called in the time step of the last accepted transfer, so valid drops at once.
  task drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_dim(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function draw_cmd_t make_cmd(logic [2:0] act, int x0, int y0, int x1, int y1,
                               int x2, int y2, int bw, int bh, logic [31:0] paint);
    draw_cmd_t c;
    c.act = act;
    c.x0 = COORD_W'(x0); c.y0 = COORD_W'(y0);
    c.x1 = COORD_W'(x1); c.y1 = COORD_W'(y1);
    c.x2 = COORD_W'(x2); c.y2 = COORD_W'(y2);
    c.bw = SIZE_W'(bw); c.bh = SIZE_W'(bh); c.paint = paint;
    return c;
  endfunction

  // Mostly near the screen, sometimes anywhere in the field's range.
  function int rand_coord(int span);
    if ($urandom_range(0, 9) == 0) return int'($signed(11'($urandom_range(0, 2047))));
    return int'($urandom_range(0, span + 40)) - 20;
  endfunction

  function draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int sel;
    c = make_cmd(ACT_LINE, rand_coord(board.scr_w), rand_coord(board.scr_h),
                 rand_coord(board.scr_w), rand_coord(board.scr_h),
                 rand_coord(board.scr_w), rand_coord(board.scr_h), 0, 0, $urandom);
    sel = $urandom_range(0, 99);
    if (sel < 1) c.act = ACT_CLEAR;
    else if (sel < 4) c.act = ACT_GRID;
    else if (sel < 20) c.act = ACT_PIXEL;
    else if (sel < 35) c.act = ACT_RECT;
    else if (sel < 55) c.act = ACT_LINE;
    else if (sel < 70) c.act = ACT_TRI;
    else if (sel < 98) c.act = ACT_READ;
    else c.act = ACT_UNUSED;
    // Keep rectangles cheap: one side small, the other may use all bits.
    if ($urandom_range(0, 1)) begin
      c.bw = SIZE_W'($urandom_range(0, 1023)); c.bh = SIZE_W'($urandom_range(0, 3));
    end else begin
      c.bw = SIZE_W'($urandom_range(0, 40)); c.bh = SIZE_W'($urandom_range(0, 40));
      if ($urandom_range(0, 7) == 0) c.bh = SIZE_W'($urandom_range(0, 1023));
      if (c.bh > 40) c.bw = SIZE_W'($urandom_range(0, 3));
    end
    if (c.act == ACT_READ && $urandom_range(0, 2) != 0) begin
      c.x0 = COORD_W'($urandom_range(0, board.scr_w - 1));
      c.y0 = COORD_W'($urandom_range(0, board.scr_h - 1));
    end
    return c;
  endfunction

  initial begin
    int dims [6][2];
    dims = '{'{0, 511}, '{256, 1}, '{1, 256}, '{37, 23}, '{256, 256}, '{100, 200}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part; the first clear makes every later on-screen read see written pixels.
    send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 32'h00000000));
    send_cmd(make_cmd(ACT_GRID, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(make_cmd(ACT_READ, 10, 20, 0, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(make_cmd(ACT_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 32'hffffffff));
    send_cmd(make_cmd(ACT_PIXEL, 255, 255, 0, 0, 0, 0, 0, 0, 32'h12345678));
    send_cmd(make_cmd(ACT_PIXEL, 256, 3, 0, 0, 0, 0, 0, 0, 32'h1));
    send_cmd(make_cmd(ACT_PIXEL, -1024, 1023, 0, 0, 0, 0, 0, 0, 32'h1));
    send_cmd(make_cmd(ACT_READ, 255, 255, 0, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(make_cmd(ACT_READ, -1, 0, 0, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(make_cmd(ACT_RECT, 250, -3, 0, 0, 0, 0, 10, 8, 32'haaaa5555));
    send_cmd(make_cmd(ACT_RECT, 5, 5, 0, 0, 0, 0, 0, 9, 32'h1));
    send_cmd(make_cmd(ACT_RECT, -500, 100, 0, 0, 0, 0, 1023, 2, 32'h55aa55aa));
    send_cmd(make_cmd(ACT_RECT, 40, -600, 0, 0, 0, 0, 2, 1023, 32'h0f0f0f0f));
    send_cmd(make_cmd(ACT_LINE, 7, 9, 7, 9, 0, 0, 0, 0, 32'hdeadbeef));
    send_cmd(make_cmd(ACT_READ, 7, 9, 0, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(make_cmd(ACT_LINE, -1024, -1024, 1023, 1023, 0, 0, 0, 0, 32'hcafe0001));
    send_cmd(make_cmd(ACT_LINE, 200, 3, 0, 70, 0, 0, 0, 0, 32'hcafe0002));
    send_cmd(make_cmd(ACT_LINE, 3, 250, 10, 0, 0, 0, 0, 0, 32'hcafe0003));
    send_cmd(make_cmd(ACT_TRI, 10, 10, 200, 40, 60, 230, 0, 0, 32'hbeef0000));
    send_cmd(make_cmd(ACT_TRI, 1023, -1024, -1024, 1023, 0, 0, 0, 0, 32'hbeef0001));
    send_cmd(make_cmd(ACT_READ, 100, 39, 0, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(make_cmd(ACT_UNUSED, 1, 1, 1, 1, 1, 1, 1, 1, 32'hffffffff));
    drain();
    // Indexes past the register list must be ignored.
    write_reg(REG_SPARE0, 9'd5);
    write_reg(REG_SPARE1, 9'd7);

    foreach (dims[p]) begin
      drain();
      write_reg(REG_WIDTH, DIM_W'(dims[p][0]));
      write_reg(REG_HEIGHT, DIM_W'(dims[p][1]));
      send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, $urandom));
      for (int n = 0; n < 330; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_cmd(rand_cmd());
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0)
      $display("[framebuffer_draw_engine] OK");
    else
      $display("[framebuffer_draw_engine] ERROR");
    $finish;
  end
endmodule
